// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the pulse train generator core.
// No dependencies; define SYNTH to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/cptg_pkg.sv =====
// Package for the counted pulse train generator: constants, codes, payload types.
// No dependencies.
`timescale 1ns / 1ps

package cptg_pkg;

    localparam int unsigned CLOCK_HZ = 16000000;

    // Quotient width of CLOCK_HZ / frequency
    localparam int CLK_W  = $clog2(CLOCK_HZ + 1);
    localparam int CNT_W  = $clog2(CLK_W);
    localparam logic [CLK_W-1:0] CLK_VEC = CLK_W'(CLOCK_HZ);

    localparam int OP_W    = 2;
    localparam int FREQ_W  = 32;
    localparam int MODE_W  = 2;
    localparam int PULSE_W = 31;
    localparam int FAULT_W = 3;
    localparam int TC_W    = 16;
    localparam int IDX_W   = 3;
    localparam int PS_W    = 10;
    localparam int TL_W    = 32;
    localparam int SH_W    = 4;
    localparam int QMAX_W  = 17;
    localparam int QCMP_W  = (CLK_W > QMAX_W) ? CLK_W : QMAX_W;

    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_START  = 2'd1;
    localparam logic [OP_W-1:0] OP_STOP   = 2'd2;
    localparam logic [OP_W-1:0] OP_RETUNE = 2'd3;

    localparam logic [MODE_W-1:0] MODE_DISCRETE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CONTINUOUS = 2'd1;

    localparam logic [FAULT_W-1:0] FAULT_NONE      = 3'd0;
    localparam logic [FAULT_W-1:0] FAULT_ACTIVE    = 3'd1;
    localparam logic [FAULT_W-1:0] FAULT_ZERO_FREQ = 3'd2;
    localparam logic [FAULT_W-1:0] FAULT_BAD_MODE  = 3'd3;
    localparam logic [FAULT_W-1:0] FAULT_ZERO_PULS = 3'd4;
    localparam logic [FAULT_W-1:0] FAULT_RANGE     = 3'd5;

    localparam int MAX_SET_LEN = 7;
    localparam logic [IDX_W-1:0]  WIDE_SET_LEN   = 3'd5;
    localparam logic [IDX_W-1:0]  NARROW_SET_LEN = 3'd7;
    // Largest quotient that still fits the compare (max compare + 1)
    localparam logic [QMAX_W-1:0] WIDE_Q_MAX     = 17'h10000;
    localparam logic [QMAX_W-1:0] NARROW_Q_MAX   = 17'h00100;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [FREQ_W-1:0]  frequency_hz;
        logic [MODE_W-1:0]  train_mode;
        logic [PULSE_W-1:0] pulse_count;
    } in_item_t;

    typedef struct packed {
        logic               pin_level;
        logic               busy_res;
        logic               accepted;
        logic [FAULT_W-1:0] fault_code;
        logic [TC_W-1:0]    compare_level;
        logic [IDX_W-1:0]   prescale_index;
    } out_item_t;

    typedef struct packed {
        logic              start;
        logic [FREQ_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [CLK_W-1:0] quotient;
    } div_sts_t;

    // log2 of the prescaler; an index past the end of the set means 1024
    function automatic logic [SH_W-1:0] div_shift(input logic wide,
                                                  input logic [IDX_W-1:0] idx);
        logic [SH_W-1:0] sh;
        sh = 4'd10;
        if (wide) begin
            case (idx)
                3'd0:    sh = 4'd0;
                3'd1:    sh = 4'd3;
                3'd2:    sh = 4'd6;
                3'd3:    sh = 4'd8;
                default: sh = 4'd10;
            endcase
        end else begin
            case (idx)
                3'd0:    sh = 4'd0;
                3'd1:    sh = 4'd3;
                3'd2:    sh = 4'd5;
                3'd3:    sh = 4'd6;
                3'd4:    sh = 4'd7;
                3'd5:    sh = 4'd8;
                default: sh = 4'd10;
            endcase
        end
        return sh;
    endfunction

endpackage

// ===== rtl/cptg_div.sv =====
// Restoring divider, one quotient bit per cycle: CLOCK_HZ / divisor.
// Depends on cptg_pkg.
`timescale 1ns / 1ps

module cptg_div (
    input  logic                clk,
    input  logic                rst_n,
    input  cptg_pkg::div_req_t  req,
    output cptg_pkg::div_sts_t  sts
);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [cptg_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [cptg_pkg::CLK_W-1:0]     rem_reg, rem_next;
    logic [cptg_pkg::CLK_W-1:0]     quo_reg, quo_next;
    logic [cptg_pkg::FREQ_W-1:0]    dvs_reg, dvs_next;
    logic [cptg_pkg::CLK_W-1:0]     trial;
    logic                           fits;

    // remainder stays below 2^step, so its top bit is free before the shift
    assign trial = {rem_reg[cptg_pkg::CLK_W-2:0], quo_reg[cptg_pkg::CLK_W-1]};
    assign fits  = cptg_pkg::FREQ_W'(trial) >= dvs_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = cptg_pkg::CLK_VEC;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? (trial - cptg_pkg::CLK_W'(dvs_reg)) : trial;
            quo_next = {quo_reg[cptg_pkg::CLK_W-2:0], fits};
            cnt_next = cnt_reg + cptg_pkg::CNT_W'(1);
            if (cnt_reg == cptg_pkg::CNT_W'(cptg_pkg::CLK_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign sts.busy     = busy_reg;
    assign sts.done     = done_reg;
    assign sts.quotient = quo_reg;

endmodule

// ===== rtl/counted_pulse_train_generator_core.sv =====
// Counted pulse train generator: CTC timer with prescaler and shared divider.
// Depends on cptg_pkg, cptg_div and assert_macros.svh.
// Tick, stop and rejected commands give their result in the cycle after acceptance.
// Start/retune past the checks runs the divider; the result is registered once it signals done.
// Throughput: one tick per cycle while results are taken; the divider holds off input.
// Reset (rst_n, async low): timer idle, pin low, no fault, 16-bit timer selected.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module counted_pulse_train_generator_core (
    input  logic                 clk,
    input  logic                 rst_n,
    // command/tick channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  cptg_pkg::in_item_t   in_item,
    // result channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output cptg_pkg::out_item_t  out_item,
    // timer width register
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data
);

    // Sequencer: idle (one transaction per cycle while results are taken) or waiting on the divider
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DIV  = 1'b1;

    logic                               state_reg, state_next;
    logic                               wide_reg, wide_next;
    logic [cptg_pkg::PS_W-1:0]          pc_reg, pc_next;
    logic [cptg_pkg::TC_W-1:0]          tc_reg, tc_next;
    logic [cptg_pkg::TC_W-1:0]          cv_reg, cv_next;
    logic [cptg_pkg::IDX_W-1:0]         choice_reg, choice_next;
    logic                               level_reg, level_next;
    logic [cptg_pkg::TL_W-1:0]          tl_reg, tl_next;
    logic                               running_reg, running_next;
    logic                               endless_reg, endless_next;
    logic [cptg_pkg::FAULT_W-1:0]       fault_reg, fault_next;

    // the pending command, held while the divider runs
    logic                               pend_retune_reg, pend_retune_next;
    logic                               pend_endless_reg, pend_endless_next;
    logic [cptg_pkg::PULSE_W-1:0]       pend_pulses_reg, pend_pulses_next;

    logic                               out_valid_reg, out_valid_next;
    cptg_pkg::out_item_t                out_item_reg, out_item_next;

    logic                               in_accept;
    logic                               load_out;
    logic                               accepted_now;
    logic [cptg_pkg::PS_W-1:0]          pmask;
    logic [cptg_pkg::TL_W-1:0]          tl_dec;

    cptg_pkg::div_req_t                 div_req;
    cptg_pkg::div_sts_t                 div_sts;

    logic                               fit_found;
    logic [cptg_pkg::IDX_W-1:0]         fit_idx;
    logic [cptg_pkg::TC_W-1:0]          fit_cmp;
    logic [cptg_pkg::IDX_W-1:0]         set_len;
    logic [cptg_pkg::QMAX_W-1:0]        q_max;

    cptg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .sts   (div_sts)
    );

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE) | (out_valid_reg & out_stall);
    assign in_accept = in_valid & ~in_stall;

    assign set_len = wide_reg ? cptg_pkg::WIDE_SET_LEN : cptg_pkg::NARROW_SET_LEN;
    assign q_max   = wide_reg ? cptg_pkg::WIDE_Q_MAX : cptg_pkg::NARROW_Q_MAX;

    // Prescaler search. P is a power of two, so CLOCK_HZ/(2*P*f) equals the
    // divider quotient shifted right by log2(P)+1. Smallest fitting index wins.
    always_comb
    begin : search
        logic [cptg_pkg::CLK_W-1:0] q_try;
        fit_found = 1'b0;
        fit_idx   = '0;
        fit_cmp   = '0;
        q_try     = '0;
        for (int i = cptg_pkg::MAX_SET_LEN - 1; i >= 0; i--)
        begin
            q_try = div_sts.quotient >>
                    (cptg_pkg::div_shift(wide_reg, cptg_pkg::IDX_W'(i)) +
                     cptg_pkg::SH_W'(1));
            if ((cptg_pkg::IDX_W'(i) < set_len) && (q_try != '0) &&
                (cptg_pkg::QCMP_W'(q_try) <= cptg_pkg::QCMP_W'(q_max)))
            begin
                fit_found = 1'b1;
                fit_idx   = cptg_pkg::IDX_W'(i);
                fit_cmp   = cptg_pkg::TC_W'(q_try - cptg_pkg::CLK_W'(1));
            end
        end
    end

    // prescaler terminal count, looked up in the set selected right now
    assign pmask  = ~({cptg_pkg::PS_W{1'b1}} << cptg_pkg::div_shift(wide_reg, choice_reg));
    assign tl_dec = (tl_reg != '0) ? (tl_reg - cptg_pkg::TL_W'(1)) : tl_reg;

    always_comb
    begin
        state_next        = state_reg;
        wide_next         = cfg_valid ? cfg_data : wide_reg;
        pc_next           = pc_reg;
        tc_next           = tc_reg;
        cv_next           = cv_reg;
        choice_next       = choice_reg;
        level_next        = level_reg;
        tl_next           = tl_reg;
        running_next      = running_reg;
        endless_next      = endless_reg;
        fault_next        = fault_reg;
        pend_retune_next  = pend_retune_reg;
        pend_endless_next = pend_endless_reg;
        pend_pulses_next  = pend_pulses_reg;
        load_out          = 1'b0;
        accepted_now      = 1'b0;
        div_req.start     = 1'b0;
        div_req.divisor   = in_item.frequency_hz;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (in_item.op)
                        cptg_pkg::OP_TICK:
                        begin
                            load_out = 1'b1;
                            if (running_reg)
                            begin
                                if (pc_reg < pmask)
                                begin
                                    pc_next = pc_reg + cptg_pkg::PS_W'(1);
                                end
                                else
                                begin
                                    pc_next = '0;
                                    if (tc_reg != cv_reg)
                                    begin
                                        tc_next = tc_reg + cptg_pkg::TC_W'(1);
                                    end
                                    else
                                    begin
                                        // compare match: toggle; a discrete train counts toward the end
                                        tc_next    = '0;
                                        level_next = ~level_reg;
                                        if (!endless_reg)
                                        begin
                                            tl_next = tl_dec;
                                            if (tl_dec == '0)
                                            begin
                                                level_next   = 1'b0;
                                                running_next = 1'b0;
                                            end
                                        end
                                    end
                                end
                            end
                        end
                        cptg_pkg::OP_STOP:
                        begin
                            load_out     = 1'b1;
                            level_next   = 1'b0;
                            running_next = 1'b0;
                        end
                        cptg_pkg::OP_START:
                        begin
                            pend_retune_next  = 1'b0;
                            pend_endless_next =
                                (in_item.train_mode == cptg_pkg::MODE_CONTINUOUS);
                            pend_pulses_next  = in_item.pulse_count;
                            // fault priority: zero pulses, bad mode, zero freq, active
                            if ((in_item.train_mode == cptg_pkg::MODE_DISCRETE) &&
                                (in_item.pulse_count == '0))
                            begin
                                load_out   = 1'b1;
                                fault_next = cptg_pkg::FAULT_ZERO_PULS;
                            end
                            else if (in_item.train_mode > cptg_pkg::MODE_CONTINUOUS)
                            begin
                                load_out   = 1'b1;
                                fault_next = cptg_pkg::FAULT_BAD_MODE;
                            end
                            else if (in_item.frequency_hz == '0)
                            begin
                                load_out   = 1'b1;
                                fault_next = cptg_pkg::FAULT_ZERO_FREQ;
                            end
                            else if (running_reg)
                            begin
                                load_out   = 1'b1;
                                fault_next = cptg_pkg::FAULT_ACTIVE;
                            end
                            else
                            begin
                                div_req.start = 1'b1;
                                state_next    = ST_DIV;
                            end
                        end
                        cptg_pkg::OP_RETUNE:
                        begin
                            pend_retune_next = 1'b1;
                            // silent reject when idle or with zero frequency
                            if (!running_reg || (in_item.frequency_hz == '0))
                            begin
                                load_out = 1'b1;
                            end
                            else
                            begin
                                div_req.start = 1'b1;
                                state_next    = ST_DIV;
                            end
                        end
                        default:
                        begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_sts.done)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                    if (!fit_found)
                    begin
                        fault_next = cptg_pkg::FAULT_RANGE;
                    end
                    else
                    begin
                        accepted_now = 1'b1;
                        cv_next      = fit_cmp;
                        choice_next  = fit_idx;
                        pc_next      = '0;
                        tc_next      = '0;
                        if (!pend_retune_reg)
                        begin
                            level_next   = 1'b0;
                            endless_next = pend_endless_reg;
                            if (!pend_endless_reg)
                            begin
                                tl_next = {pend_pulses_reg, 1'b0};
                            end
                            running_next = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result register: refilled on a new result, drained when not stalled
    assign out_valid_next = load_out | (out_valid_reg & out_stall);

    always_comb
    begin
        out_item_next = out_item_reg;
        if (load_out)
        begin
            out_item_next.pin_level      = level_next;
            out_item_next.busy_res       = running_next;
            out_item_next.accepted       = accepted_now;
            out_item_next.fault_code     = fault_next;
            out_item_next.compare_level  = cv_next;
            out_item_next.prescale_index = choice_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wide_reg      <= 1'b1;
            pc_reg        <= '0;
            tc_reg        <= '0;
            cv_reg        <= '0;
            choice_reg    <= '0;
            level_reg     <= 1'b0;
            tl_reg        <= '0;
            running_reg   <= 1'b0;
            endless_reg   <= 1'b0;
            fault_reg     <= cptg_pkg::FAULT_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wide_reg      <= wide_next;
            pc_reg        <= pc_next;
            tc_reg        <= tc_next;
            cv_reg        <= cv_next;
            choice_reg    <= choice_next;
            level_reg     <= level_next;
            tl_reg        <= tl_next;
            running_reg   <= running_next;
            endless_reg   <= endless_next;
            fault_reg     <= fault_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_retune_reg  <= pend_retune_next;
        pend_endless_reg <= pend_endless_next;
        pend_pulses_reg  <= pend_pulses_next;
        out_item_reg     <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    `ASSERT_IMPLIES(a_div_out_empty, clk, rst_n, state_reg == ST_DIV, !out_valid_reg, "result pending while divider runs")
    `ASSERT_IMPLIES(a_done_in_div, clk, rst_n, div_sts.done, state_reg == ST_DIV, "divider finished outside a command")
    `ASSERT_IMPLIES(a_div_alive, clk, rst_n, (state_reg == ST_DIV) && !div_sts.done, div_sts.busy, "sequencer waits on an idle divider")
    `ASSERT_IMPLIES(a_count_live, clk, rst_n, running_reg && !endless_reg, tl_reg != '0, "discrete train running with no toggles left")
    `ASSERT_NEXT(a_stop_low, clk, rst_n, in_accept && (in_item.op == cptg_pkg::OP_STOP), !running_reg && !level_reg, "stop left the train running")

endmodule
